// ----- rtl/uhk_pkg.sv -----
package uhk_pkg;

    localparam logic [7:0]  LEAD_BYTE   = 8'hE3;
    localparam logic [7:0]  CONT_MASK   = 8'hC0;
    localparam logic [7:0]  CONT_TAG    = 8'h80;
    localparam logic [7:0]  LOW4_MASK   = 8'h0F;
    localparam logic [7:0]  LOW6_MASK   = 8'h3F;
    localparam logic [15:0] HIRA_FIRST  = 16'h3041;
    localparam logic [15:0] HIRA_LAST   = 16'h3096;
    localparam logic [15:0] KATA_OFFSET = 16'h0060;
    localparam logic [7:0]  THREE_TAG   = 8'hE0;

    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Result bytes produced by one input byte, oldest in data[0].
    typedef struct packed {
        logic [1:0]                   count;
        logic [MAX_RESULTS-1:0][7:0]  data;
    } uhk_group_t;

endpackage

// ----- rtl/utf8_hiragana_to_katakana.sv -----
// UTF-8 hiragana to katakana stream converter.
// Input channel s_*: one byte per request (s_in_byte) with s_end_of_text on the
// final byte of a text, which flushes anything held. Output channel m_*: one
// byte per request (m_out_byte); m_run_last marks the final byte produced by
// a given input byte. Both channels use valid/ready.
// A lead byte 0xE3 and one continuation byte are held until the sequence is
// complete; a hiragana code point is re-encoded as katakana, anything else
// passes unchanged. cfg_we/cfg_wdata write convert_enable (reset 1); write it
// only while the block is idle.
// A request waits in the input register; its result bytes then enter the
// eight-entry output queue once it has room and are offered from then on.
// Throughput: one byte per cycle sustained while the receiver is ready. An input
// byte may yield up to three bytes, drained one a cycle while m_ready is high;
// the input stalls only while the queue lacks room for three more bytes, which
// a held sequence never causes at full rate. Reset (aresetn low, synchronous)
// empties the queue, drops held bytes and sets convert_enable. When the receiver
// stalls, the queue fills and s_ready falls; no byte is lost.
module utf8_hiragana_to_katakana (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last
);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_end_reg;
    logic                room;
    logic                fire;
    uhk_pkg::uhk_group_t group;

    always_comb begin
        fire    = in_valid_reg && room;
        s_ready = !in_valid_reg || room;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
            in_end_reg  <= s_end_of_text;
        end
    end

    uhk_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fire        (fire),
        .in_byte     (in_byte_reg),
        .end_of_text (in_end_reg),
        .group       (group)
    );

    uhk_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .group      (group),
        .room       (room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_last (m_run_last)
    );

endmodule

// ----- rtl/uhk_decode.sv -----
module uhk_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              fire,
    input  logic [7:0]        in_byte,
    input  logic              end_of_text,
    output uhk_pkg::uhk_group_t group
);

    logic        convert_enable_reg;
    logic [1:0]  held_count_reg, held_count_next;
    logic [7:0]  held_second_reg, held_second_next;

    logic        is_cont;
    logic        is_lead_hold;
    logic [15:0] code_point;
    logic [15:0] kata;
    logic        is_hira;

    always_comb begin
        is_cont      = (in_byte & uhk_pkg::CONT_MASK) == uhk_pkg::CONT_TAG;
        is_lead_hold = (in_byte == uhk_pkg::LEAD_BYTE) && !end_of_text;
        code_point   = {(uhk_pkg::LEAD_BYTE[3:0] & uhk_pkg::LOW4_MASK[3:0]),
                        (held_second_reg[5:0] & uhk_pkg::LOW6_MASK[5:0]),
                        (in_byte[5:0] & uhk_pkg::LOW6_MASK[5:0])};
        is_hira      = (code_point >= uhk_pkg::HIRA_FIRST) &&
                       (code_point <= uhk_pkg::HIRA_LAST);
        kata         = code_point + uhk_pkg::KATA_OFFSET;
    end

    always_comb begin
        group            = '0;
        held_count_next  = 2'd0;
        held_second_next = held_second_reg;
        if (!convert_enable_reg) begin
            // pass through: release anything held, then the byte itself
            case (held_count_reg)
                2'd1: begin
                    group.count   = 2'd2;
                    group.data[0] = uhk_pkg::LEAD_BYTE;
                    group.data[1] = in_byte;
                end
                2'd2: begin
                    group.count   = 2'd3;
                    group.data[0] = uhk_pkg::LEAD_BYTE;
                    group.data[1] = held_second_reg;
                    group.data[2] = in_byte;
                end
                default: begin
                    group.count   = 2'd1;
                    group.data[0] = in_byte;
                end
            endcase
        end else begin
            case (held_count_reg)
                2'd1: begin
                    if (is_cont && !end_of_text) begin
                        held_second_next = in_byte;
                        held_count_next  = 2'd2;
                    end else if (!is_cont && is_lead_hold) begin
                        group.count     = 2'd1;
                        group.data[0]   = uhk_pkg::LEAD_BYTE;
                        held_count_next = 2'd1;
                    end else begin
                        group.count   = 2'd2;
                        group.data[0] = uhk_pkg::LEAD_BYTE;
                        group.data[1] = in_byte;
                    end
                end
                2'd2: begin
                    if (is_cont && is_hira) begin
                        group.count   = 2'd3;
                        group.data[0] = uhk_pkg::THREE_TAG | {4'h0, kata[15:12]};
                        group.data[1] = uhk_pkg::CONT_TAG | {2'b00, kata[11:6]};
                        group.data[2] = uhk_pkg::CONT_TAG | {2'b00, kata[5:0]};
                    end else if (!is_cont && is_lead_hold) begin
                        group.count     = 2'd2;
                        group.data[0]   = uhk_pkg::LEAD_BYTE;
                        group.data[1]   = held_second_reg;
                        held_count_next = 2'd1;
                    end else begin
                        group.count   = 2'd3;
                        group.data[0] = uhk_pkg::LEAD_BYTE;
                        group.data[1] = held_second_reg;
                        group.data[2] = in_byte;
                    end
                end
                default: begin
                    if (is_lead_hold) begin
                        held_count_next = 2'd1;
                    end else begin
                        group.count   = 2'd1;
                        group.data[0] = in_byte;
                    end
                end
            endcase
        end
        // no request consumed: emit nothing and hold state
        if (!fire) begin
            group            = '0;
            held_count_next  = held_count_reg;
            held_second_next = held_second_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            convert_enable_reg <= 1'b1;
            held_count_reg     <= 2'd0;
            held_second_reg    <= 8'h00;
        end else begin
            if (cfg_we) begin
                convert_enable_reg <= cfg_wdata;
            end
            held_count_reg  <= held_count_next;
            held_second_reg <= held_second_next;
        end
    end

`ifndef ASSERT_OFF
    a_held_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg != 2'd3)
        else $error("held count reached an unused code");

    a_pass_holds_nothing: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !convert_enable_reg |=> held_count_reg == 2'd0)
        else $error("bytes held while conversion is off");

    a_end_flushes: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && end_of_text |=> held_count_reg == 2'd0)
        else $error("bytes held after end of text");
`endif

endmodule

// ----- rtl/uhk_out_queue.sv -----
module uhk_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  uhk_pkg::uhk_group_t group,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_run_last
);

    localparam int AW = uhk_pkg::QUEUE_AW;
    localparam int CW = uhk_pkg::QUEUE_CW;

    logic [7:0]    byte_mem [uhk_pkg::QUEUE_DEPTH];
    logic          last_mem [uhk_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    always_comb begin
        pop        = m_valid && m_ready;
        // room for a full group once this cycle's pop has left
        room       = ({1'b0, count_reg} + CW'(uhk_pkg::MAX_RESULTS)) <=
                     ({1'b0, CW'(uhk_pkg::QUEUE_DEPTH)} + {{CW{1'b0}}, pop});
        m_valid    = count_reg != '0;
        m_out_byte = byte_mem[rd_ptr_reg];
        m_run_last = last_mem[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg + AW'(group.count);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + CW'(group.count) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < uhk_pkg::MAX_RESULTS; i++) begin
            if (i < int'(group.count)) begin
                byte_mem[wr_ptr_reg + AW'(i)] <= group.data[i];
                last_mem[wr_ptr_reg + AW'(i)] <= (i == int'(group.count) - 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(uhk_pkg::QUEUE_DEPTH))
        else $error("output queue overfilled");

    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[AW-1:0])
        else $error("queue pointers disagree with fill count");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_run_last))
        else $error("result changed while stalled");
`endif

endmodule

// ----- tb/utf8_hiragana_to_katakana_tb.sv -----
`timescale 1ns / 1ps

module utf8_hiragana_to_katakana_tb;

    typedef enum logic [1:0] {HELD_NONE, HELD_LEAD, HELD_PAIR} held_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_rec_t;

    typedef struct packed {
        logic [7:0]  in_b;
        logic        eot;
        logic        typed;
        logic [1:0]  n;
        logic [23:0] bytes;
    } dir_row_t;

    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 20;
    localparam int HOLD_CYCLES = 80;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       s_end_of_text;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_run_last;

    // predictor state
    logic       conv_on;
    held_t      held_st;
    logic [7:0] held_cont;
    logic [7:0] step_bytes[$];
    out_rec_t   katakana_q[$];

    // typed expectation travelling with the request on the input channel
    logic        drv_typed;
    logic [1:0]  drv_nexp;
    logic [23:0] drv_exp;

    dir_row_t dir_rows[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int hold_ack;
    int hold_left;
    int err_cnt;
    int bytes_in;
    int bytes_out;
    int kata_made;
    int input_stalls;

    int phase_cfg [NUM_PHASES] = '{0, 1, 1, 0, 1, 1};
    int phase_send[NUM_PHASES] = '{0, 53, 0, 29, 29, 0};
    int phase_recv[NUM_PHASES] = '{0, 0, 53, 29, 29, 0};

    utf8_hiragana_to_katakana dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic note_error(input string what);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
    endtask

    function automatic logic is_cont(input logic [7:0] b);
        return (b & uhk_pkg::CONT_MASK) == uhk_pkg::CONT_TAG;
    endfunction

    task automatic add_step(input logic [7:0] b);
        step_bytes = {step_bytes, b};
    endtask

    // a byte seen with nothing held: hold a lead unless the text ends here
    task automatic take_fresh(input logic [7:0] b, input logic eot);
        if (b == uhk_pkg::LEAD_BYTE && !eot) begin
            held_st = HELD_LEAD;
        end else begin
            held_st = HELD_NONE;
            add_step(b);
        end
    endtask

    task automatic convert_byte(input logic [7:0] b, input logic eot);
        logic [15:0] cp;
        logic [15:0] kata;
        step_bytes.delete();
        if (!conv_on) begin
            if (held_st == HELD_LEAD || held_st == HELD_PAIR) begin
                add_step(uhk_pkg::LEAD_BYTE);
            end
            if (held_st == HELD_PAIR) begin
                add_step(held_cont);
            end
            add_step(b);
            held_st = HELD_NONE;
        end else begin
            case (held_st)
                HELD_LEAD: begin
                    if (is_cont(b) && eot) begin
                        add_step(uhk_pkg::LEAD_BYTE);
                        add_step(b);
                        held_st = HELD_NONE;
                    end else if (is_cont(b)) begin
                        held_cont = b;
                        held_st = HELD_PAIR;
                    end else begin
                        add_step(uhk_pkg::LEAD_BYTE);
                        take_fresh(b, eot);
                    end
                end
                HELD_PAIR: begin
                    if (is_cont(b)) begin
                        cp = (16'(uhk_pkg::LEAD_BYTE & uhk_pkg::LOW4_MASK) << 12)
                           | (16'(held_cont & uhk_pkg::LOW6_MASK) << 6)
                           | 16'(b & uhk_pkg::LOW6_MASK);
                        if (cp >= uhk_pkg::HIRA_FIRST && cp <= uhk_pkg::HIRA_LAST) begin
                            kata = cp + uhk_pkg::KATA_OFFSET;
                            add_step(uhk_pkg::THREE_TAG | 8'(kata[15:12]));
                            add_step(uhk_pkg::CONT_TAG | 8'(kata[11:6]));
                            add_step(uhk_pkg::CONT_TAG | 8'(kata[5:0]));
                            kata_made++;
                        end else begin
                            add_step(uhk_pkg::LEAD_BYTE);
                            add_step(held_cont);
                            add_step(b);
                        end
                        held_st = HELD_NONE;
                    end else begin
                        add_step(uhk_pkg::LEAD_BYTE);
                        add_step(held_cont);
                        take_fresh(b, eot);
                    end
                end
                default: begin
                    take_fresh(b, eot);
                end
            endcase
        end
    endtask

    // predict on every accepted request, check every accepted result byte
    always @(posedge aclk) begin : watch
        out_rec_t want;
        out_rec_t rec;
        int i;
        if (aresetn) begin
            if (cfg_we) begin
                conv_on = cfg_wdata;
            end
            if (s_valid && !s_ready) begin
                input_stalls++;
            end
            if (s_valid && s_ready) begin
                convert_byte(s_in_byte, s_end_of_text);
                bytes_in++;
                if (drv_typed) begin
                    for (i = 0; i < drv_nexp; i++) begin
                        rec = {drv_exp[23 - 8*i -: 8], i == drv_nexp - 1};
                        katakana_q = {katakana_q, rec};
                    end
                end else begin
                    for (i = 0; i < step_bytes.size(); i++) begin
                        rec = {step_bytes[i], i == step_bytes.size() - 1};
                        katakana_q = {katakana_q, rec};
                    end
                end
            end
            if (m_valid && m_ready) begin
                bytes_out++;
                if (katakana_q.size() == 0) begin
                    note_error($sformatf("unexpected byte %02h last %0b",
                                         m_out_byte, m_run_last));
                end else begin
                    want = katakana_q.pop_front();
                    if (m_out_byte !== want.data || m_run_last !== want.last) begin
                        note_error($sformatf("byte %02h last %0b, expected %02h last %0b",
                                             m_out_byte, m_run_last, want.data, want.last));
                    end
                end
            end
        end
    end

    // receiver: random stall, or a long hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_in_byte = b;
        s_end_of_text = eot;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drain();
        while (katakana_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic add_row(input logic [7:0] b, input logic eot, input logic typed,
                           input logic [1:0] n, input logic [23:0] bytes);
        dir_row_t row;
        row = '{in_b: b, eot: eot, typed: typed, n: n, bytes: bytes};
        dir_rows = {dir_rows, row};
    endtask

    // mostly well-formed UTF-8 with random content, some broken runs and noise
    task automatic send_random_token(output int sent);
        logic [7:0]  seq[$];
        logic [15:0] cp;
        int          kind;
        int          i;
        int          eot_pct;
        kind = $urandom_range(99);
        if (kind < 35) begin
            cp = 16'($urandom_range(uhk_pkg::HIRA_FIRST, uhk_pkg::HIRA_LAST));
            seq = {uhk_pkg::LEAD_BYTE, uhk_pkg::CONT_TAG | 8'(cp[11:6]),
                   uhk_pkg::CONT_TAG | 8'(cp[5:0])};
        end else if (kind < 50) begin
            cp = 16'($urandom_range(16'h3000, 16'h3FFF));
            seq = {uhk_pkg::LEAD_BYTE, uhk_pkg::CONT_TAG | 8'(cp[11:6]),
                   uhk_pkg::CONT_TAG | 8'(cp[5:0])};
        end else if (kind < 62) begin
            seq = {8'($urandom_range(127))};
        end else if (kind < 72) begin
            seq = {8'($urandom_range(8'hE0, 8'hEF)),
                   uhk_pkg::CONT_TAG | 8'($urandom_range(63)),
                   uhk_pkg::CONT_TAG | 8'($urandom_range(63))};
        end else if (kind < 86) begin
            seq = {seq, uhk_pkg::LEAD_BYTE};
            if ($urandom_range(1)) begin
                seq = {seq, uhk_pkg::CONT_TAG | 8'($urandom_range(63))};
            end
            seq = {seq, 8'($urandom_range(255))};
        end else begin
            for (i = 0; i <= $urandom_range(2); i++) begin
                seq = {seq, 8'($urandom_range(255))};
            end
        end
        drv_typed = 1'b0;
        for (i = 0; i < seq.size(); i++) begin
            eot_pct = (i == seq.size() - 1) ? 12 : 5;
            send_byte(seq[i], $urandom_range(99) < eot_pct);
        end
        sent = seq.size();
    endtask

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int ph;
        int n;
        int sent;
        logic paused;

        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        s_valid = 1'b0;
        s_in_byte = 8'h00;
        s_end_of_text = 1'b0;
        m_ready = 1'b0;
        drv_typed = 1'b0;
        drv_nexp = 2'd0;
        drv_exp = 24'h0;
        conv_on = 1'b1;
        held_st = HELD_NONE;
        held_cont = 8'h00;
        hold_req = 0;
        hold_ack = 0;
        hold_left = 0;
        err_cnt = 0;
        bytes_in = 0;
        bytes_out = 0;
        kata_made = 0;
        input_stalls = 0;
        paused = 1'b0;
        send_idle_pct = 29;
        recv_stall_pct = 29;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // plain bytes at the range ends and a lone continuation
        add_row(8'h00, 1'b0, 1'b1, 2'd1, 24'h00_0000);
        add_row(8'hFF, 1'b0, 1'b1, 2'd1, 24'hFF_0000);
        add_row(8'h80, 1'b0, 1'b1, 2'd1, 24'h80_0000);
        // first and last hiragana
        add_row(uhk_pkg::LEAD_BYTE, 1'b0, 1'b1, 2'd0, 24'h0);
        add_row(8'h81, 1'b0, 1'b1, 2'd0, 24'h0);
        add_row(8'h81, 1'b0, 1'b1, 2'd3, 24'hE3_82A1);
        add_row(uhk_pkg::LEAD_BYTE, 1'b0, 1'b1, 2'd0, 24'h0);
        add_row(8'h82, 1'b0, 1'b1, 2'd0, 24'h0);
        add_row(8'h96, 1'b0, 1'b1, 2'd3, 24'hE3_83B6);
        // just past the hiragana block: unchanged
        add_row(uhk_pkg::LEAD_BYTE, 1'b0, 1'b0, 2'd0, 24'h0);
        add_row(8'h82, 1'b0, 1'b0, 2'd0, 24'h0);
        add_row(8'h97, 1'b0, 1'b0, 2'd0, 24'h0);
        // broken after the lead, then after the first continuation
        add_row(uhk_pkg::LEAD_BYTE, 1'b0, 1'b0, 2'd0, 24'h0);
        add_row(8'h41, 1'b0, 1'b0, 2'd0, 24'h0);
        add_row(uhk_pkg::LEAD_BYTE, 1'b0, 1'b0, 2'd0, 24'h0);
        add_row(8'h81, 1'b0, 1'b0, 2'd0, 24'h0);
        add_row(8'h41, 1'b0, 1'b0, 2'd0, 24'h0);
        // end of text flushes lead and continuation bytes
        add_row(uhk_pkg::LEAD_BYTE, 1'b0, 1'b0, 2'd0, 24'h0);
        add_row(uhk_pkg::LEAD_BYTE, 1'b1, 1'b0, 2'd0, 24'h0);
        add_row(uhk_pkg::LEAD_BYTE, 1'b1, 1'b1, 2'd1, 24'hE3_0000);
        add_row(uhk_pkg::LEAD_BYTE, 1'b0, 1'b0, 2'd0, 24'h0);
        add_row(8'h81, 1'b1, 1'b0, 2'd0, 24'h0);
        // leave a pair held across the switch to pass-through
        add_row(uhk_pkg::LEAD_BYTE, 1'b0, 1'b0, 2'd0, 24'h0);
        add_row(8'h82, 1'b0, 1'b0, 2'd0, 24'h0);

        foreach (dir_rows[i]) begin
            drv_typed = dir_rows[i].typed;
            drv_nexp = dir_rows[i].n;
            drv_exp = dir_rows[i].bytes;
            send_byte(dir_rows[i].in_b, dir_rows[i].eot);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drain();
            // held bytes yield nothing; let the input register settle first
            repeat (4) @(negedge aclk);
            cfg_we = 1'b1;
            cfg_wdata = phase_cfg[ph][0];
            @(negedge aclk);
            cfg_we = 1'b0;

            send_idle_pct = phase_send[ph];
            recv_stall_pct = phase_recv[ph];
            if (phase_recv[ph] != 0 && phase_send[ph] == 0) begin
                // starve the output so the queue fills and the input backs up
                hold_req <= hold_req + 1;
            end
            n = 0;
            while (n < PHASE_ITEMS) begin
                if (ph == 4 && n >= PHASE_ITEMS / 2 && !paused) begin
                    wait_drain();
                    paused = 1'b1;
                end
                send_random_token(sent);
                n += sent;
            end
        end

        wait_drain();
        repeat (20) @(negedge aclk);
        if (katakana_q.size() != 0) begin
            note_error($sformatf("%0d result bytes never arrived", katakana_q.size()));
        end

        $display("Run covered %0d input bytes over %0d traffic phases, %0d result bytes checked",
                 bytes_in, NUM_PHASES, bytes_out);
        $display("Hiragana converted: %0d; cycles with the input held off: %0d",
                 kata_made, input_stalls);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
